// File: src/ctw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none
package ctw_pkg;

  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = 16;
  localparam int CADDR_W = 11;
  localparam int ROW_O_W = 5;
  localparam int COL_O_W = 7;

  localparam int TAB_STOP = 4;
  localparam int TAB_BITS = $clog2(TAB_STOP);

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

  typedef struct packed {
    logic [CELL_W-1:0]  read_cell;
    logic [ROW_O_W-1:0] cursor_row;
    logic [COL_O_W-1:0] cursor_col;
  } res_t;

endpackage
`default_nettype wire

// File: src/text_console_writer.sv
// Text console writer: ROWS x COLS cell store, cursor, one command at a time.
// Put character, carriage return, cell read and backspace: result registered through
//   EXEC and DONE (a read also passes RDWAIT); tab blanks one cell per cycle up to the
//   next tab stop or the row end, and a pending wrap first takes the new line.
// A newline on the bottom row copies the store up one row, one cell per cycle through
//   the read port and the write port. Clear refills every cell with a blank.
// After reset the store is initialized one cell per cycle, with in_ready low; the
//   attribute register resets to 0x07.
`default_nettype none
module text_console_writer
  import ctw_pkg::*;
#(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CMD_W-1:0]   cmd,
  input  wire logic [CHAR_W-1:0]  char_code,
  input  wire logic [CADDR_W-1:0] cell_address,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CELL_W-1:0]       read_cell,
  output logic [ROW_O_W-1:0]      cursor_row,
  output logic [COL_O_W-1:0]      cursor_col,
  input  wire logic               cfg_wr_en,
  input  wire logic [ATTR_W-1:0]  cfg_wr_data
);

  logic [ATTR_W-1:0] text_attribute;
  logic              res_valid;
  logic              res_take;
  res_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (cfg_wr_en) begin
      text_attribute <= cfg_wr_data;
    end
  end

  ctw_engine #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .char_code    (char_code),
    .cell_address (cell_address),
    .attr         (text_attribute),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  // Output register: load when empty or being drained.
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      read_cell  <= res.read_cell;
      cursor_row <= res.cursor_row;
      cursor_col <= res.cursor_col;
    end
  end

endmodule
`default_nettype wire

// File: src/ctw_screen_mem.sv
// Screen cell store: one write port, one read port with registered data.
`default_nettype none
module ctw_screen_mem
  import ctw_pkg::*;
#(
  parameter int DEPTH = DEF_ROWS * DEF_COLS,
  parameter int AW    = $clog2(DEF_ROWS * DEF_COLS)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/ctw_engine.sv
// Command sequencer: cursor state and read-modify-write access to the cell store.
`default_nettype none
module ctw_engine
  import ctw_pkg::*;
#(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CMD_W-1:0]   cmd,
  input  wire logic [CHAR_W-1:0]  char_code,
  input  wire logic [CADDR_W-1:0] cell_address,
  input  wire logic [ATTR_W-1:0]  attr,
  output logic                    res_valid,
  input  wire logic               res_take,
  output res_t                    res
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS + 1);

  localparam logic [AW-1:0] COLS_A    = AW'(COLS);
  localparam logic [AW-1:0] SCR_END   = AW'(CELLS - COLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COLS_C    = CW'(COLS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_SBLANK = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]         state;
  logic [CMD_W-1:0]   cmd_q;
  logic [CHAR_W-1:0]  ch_q;
  logic [CADDR_W-1:0] addr_q;
  logic [RW-1:0]      row;
  logic [CW-1:0]      col;
  logic [AW-1:0]      row_base;
  logic [AW-1:0]      idx;
  logic               cp_valid;
  logic [AW-1:0]      cp_dst;
  logic [CELL_W-1:0]  rd_q;
  logic               init_fill;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [CELL_W-1:0]  mem_rdata;

  logic [AW-1:0]      cur_addr;
  logic [CW-1:0]      col_inc;
  logic               at_home;
  logic               rd_in_range;
  logic [CELL_W-1:0]  blank;
  logic [31:0]        row_ext;
  logic [31:0]        col_ext;

  assign cur_addr    = row_base + AW'(col);
  assign col_inc     = col + CW'(1);
  assign at_home     = (row == '0) && (col == '0);
  assign rd_in_range = 32'(addr_q) < 32'(CELLS);
  assign blank       = {attr, CH_SPACE};

  ctw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Memory port control; the scroll copy owns the write port while it runs.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = blank;
    mem_re    = 1'b0;
    mem_raddr = idx + COLS_A;
    if (cp_valid) begin
      mem_we    = 1'b1;
      mem_waddr = cp_dst;
      mem_wdata = mem_rdata;
    end
    case (state)
      S_EXEC: begin
        if (cmd_q == CMD_PUT) begin
          case (ch_q)
            CH_BS: begin
              if (!at_home) begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr - AW'(1);
              end
            end
            CH_LF, CH_CR: begin
            end
            default: begin
              if (col != COLS_C) begin
                mem_we    = 1'b1;
                mem_wdata = (ch_q == CH_TAB) ? blank : {attr, ch_q};
              end
            end
          endcase
        end else if (cmd_q == CMD_READ && rd_in_range) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(addr_q);
        end
      end
      S_SCROLL: begin
        mem_re = (idx != SCR_END);
      end
      S_SBLANK: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = init_fill ? CELL_RESET : blank;
      end
      default: begin
      end
    endcase
  end

  // Hold the accepted transaction and the scroll copy destination.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q  <= cmd;
      ch_q   <= char_code;
      addr_q <= cell_address;
    end
    if (state == S_SCROLL) begin
      cp_dst <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      init_fill <= 1'b1;
      idx       <= '0;
      row       <= '0;
      col       <= '0;
      row_base  <= '0;
      cp_valid  <= 1'b0;
      rd_q      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rd_q  <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_q)
            CMD_PUT: begin
              case (ch_q)
                CH_BS: begin
                  state <= S_DONE;
                  if (!at_home) begin
                    if (col == '0) begin
                      row      <= row - RW'(1);
                      row_base <= row_base - COLS_A;
                      col      <= LAST_COL;
                    end else begin
                      col <= col - CW'(1);
                    end
                  end
                end
                CH_CR: begin
                  col   <= '0;
                  state <= S_DONE;
                end
                CH_LF: begin
                  col <= '0;
                  if (row != LAST_ROW) begin
                    row      <= row + RW'(1);
                    row_base <= row_base + COLS_A;
                    state    <= S_DONE;
                  end else begin
                    idx   <= '0;
                    state <= S_SCROLL;
                  end
                end
                default: begin
                  if (col == COLS_C) begin
                    // wrap pending: take the new line, then come back here
                    col <= '0;
                    if (row != LAST_ROW) begin
                      row      <= row + RW'(1);
                      row_base <= row_base + COLS_A;
                    end else begin
                      idx   <= '0;
                      state <= S_SCROLL;
                    end
                  end else begin
                    col <= col_inc;
                    if (ch_q != CH_TAB || col_inc[TAB_BITS-1:0] == '0
                        || col_inc == COLS_C) begin
                      state <= S_DONE;
                    end
                  end
                end
              endcase
            end
            CMD_CLEAR: begin
              idx      <= '0;
              row      <= '0;
              col      <= '0;
              row_base <= '0;
              state    <= S_FILL;
            end
            CMD_READ: begin
              state <= rd_in_range ? S_RDWAIT : S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_SCROLL: begin
          if (idx == SCR_END) begin
            cp_valid <= 1'b0;
            state    <= S_SBLANK;
          end else begin
            cp_valid <= 1'b1;
            idx      <= idx + AW'(1);
          end
        end
        S_SBLANK: begin
          if (idx == LAST_CELL) begin
            state <= (ch_q == CH_LF) ? S_DONE : S_EXEC;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_FILL: begin
          if (idx == LAST_CELL) begin
            init_fill <= 1'b0;
            state     <= init_fill ? S_IDLE : S_DONE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_RDWAIT: begin
          rd_q  <= mem_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign row_ext        = 32'(row);
  assign col_ext        = 32'(col);
  assign in_ready       = (state == S_IDLE);
  assign res_valid      = (state == S_DONE);
  assign res.read_cell  = rd_q;
  assign res.cursor_row = row_ext[ROW_O_W-1:0];
  assign res.cursor_col = col_ext[COL_O_W-1:0];

  a_copy_only_in_scroll: assert property (@(posedge clk) disable iff (rst)
    cp_valid |-> (state == S_SCROLL))
    else $error("scroll copy write outside scroll");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col <= COLS_C)
    else $error("cursor column beyond row width");

  a_row_base_tracks_row: assert property (@(posedge clk) disable iff (rst)
    row_base == AW'(32'(row) * COLS))
    else $error("row base out of step with cursor row");

  a_read_issued: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDWAIT) |-> $past(mem_re))
    else $error("read wait without a memory read");

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for text_console_writer: console traffic against a cell-store predictor.
`timescale 1ns / 1ps
module testbench;
  import ctw_pkg::*;

  localparam int NCOLS = DEF_COLS;
  localparam int NROWS = DEF_ROWS;
  localparam int NCELLS = NCOLS * NROWS;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int RANDOM_OPS = 700;
  localparam int PHASES = 6;
  localparam int SETTLE_CYCLES = 16;
  // a scroll or clear walks the whole store; allow that many times over
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  char_code;
    logic [CADDR_W-1:0] cell_address;
  } console_op_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = '0;
  logic [CHAR_W-1:0]    char_code = '0;
  logic [CADDR_W-1:0]   cell_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CELL_W-1:0]    read_cell;
  logic [ROW_O_W-1:0]   cursor_row;
  logic [COL_O_W-1:0]   cursor_col;
  logic                 cfg_wr_en = 1'b0;
  logic [ATTR_W-1:0]    cfg_wr_data = '0;

  // predicted console state
  logic [CELL_W-1:0]    shadow_cells [NCELLS];
  int                   shadow_row;
  int                   shadow_col;
  logic [ATTR_W-1:0]    shadow_attr;

  console_op_t          pending_ops [$];
  res_t                 expected_results [$];
  console_op_t          next_op;
  res_t                 want;

  int  errors = 0;
  int  ops_queued = 0;
  int  results_seen = 0;
  int  scroll_count = 0;
  int  clear_count = 0;
  int  read_count = 0;
  int  attr_writes = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  sink_stall = 0;
  int  calm_left = 0;
  logic calm = 1'b0;
  logic in_fired = 1'b0;

  text_console_writer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .char_code    (char_code),
    .cell_address (cell_address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_cell    (read_cell),
    .cursor_row   (cursor_row),
    .cursor_col   (cursor_col),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #6 clk = ~clk;

  function automatic void blank_cell(int r, int c);
    shadow_cells[r * NCOLS + c] = {shadow_attr, CH_SPACE};
  endfunction

  function automatic void line_feed();
    if (shadow_row < NROWS - 1) begin
      shadow_row++;
    end else begin
      for (int i = 0; i < NCELLS - NCOLS; i++) shadow_cells[i] = shadow_cells[i + NCOLS];
      for (int c = 0; c < NCOLS; c++) blank_cell(NROWS - 1, c);
      scroll_count++;
    end
    shadow_col = 0;
  endfunction

  // advance the console state by one transaction and return what it reports
  function automatic res_t console_step(console_op_t op);
    res_t r;
    int   stop;
    r = '0;
    case (op.cmd)
      CMD_PUT: begin
        case (op.char_code)
          CH_BS: begin
            if (shadow_col != 0 || shadow_row != 0) begin
              if (shadow_col == 0) begin
                shadow_row--;
                shadow_col = NCOLS;
              end
              shadow_col--;
              blank_cell(shadow_row, shadow_col);
            end
          end
          CH_LF: line_feed();
          CH_CR: shadow_col = 0;
          CH_TAB: begin
            if (shadow_col >= NCOLS) line_feed();
            stop = shadow_col + TAB_STOP - (shadow_col % TAB_STOP);
            if (stop > NCOLS) stop = NCOLS;
            while (shadow_col < stop) begin
              blank_cell(shadow_row, shadow_col);
              shadow_col++;
            end
          end
          default: begin
            // full row: wrap before writing
            if (shadow_col >= NCOLS) line_feed();
            shadow_cells[shadow_row * NCOLS + shadow_col] = {shadow_attr, op.char_code};
            shadow_col++;
          end
        endcase
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NCELLS; i++) shadow_cells[i] = {shadow_attr, CH_SPACE};
        shadow_row = 0;
        shadow_col = 0;
        clear_count++;
      end
      CMD_READ: begin
        read_count++;
        if (op.cell_address < NCELLS) r.read_cell = shadow_cells[op.cell_address];
      end
      default: begin
      end
    endcase
    r.cursor_row = shadow_row[ROW_O_W-1:0];
    r.cursor_col = shadow_col[COL_O_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_op(logic [CMD_W-1:0] c, logic [CHAR_W-1:0] ch,
                                   logic [CADDR_W-1:0] addr);
    pending_ops.push_back('{cmd: c, char_code: ch, cell_address: addr});
    if (c != CMD_NONE) ops_queued++;
  endfunction

  function automatic void add_random_burst();
    int kind;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++)
        queue_op(CMD_PUT, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(32, 126),
                 $urandom_range(0, 2047));
    end else if (kind < 45) begin
      len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++)
        queue_op(CMD_PUT, ($urandom_range(0, 4) == 0) ? CH_CR : CH_LF, $urandom_range(0, 2047));
    end else if (kind < 55) begin
      len = $urandom_range(1, 100);
      for (int i = 0; i < len; i++) queue_op(CMD_PUT, CH_BS, $urandom_range(0, 2047));
    end else if (kind < 63) begin
      len = $urandom_range(1, 25);
      for (int i = 0; i < len; i++) queue_op(CMD_PUT, CH_TAB, $urandom_range(0, 2047));
    end else if (kind < 68) begin
      queue_op(CMD_PUT, CH_CR, $urandom_range(0, 2047));
    end else if (kind < 83) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        queue_op(CMD_READ, $urandom_range(0, 255),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                             : $urandom_range(0, NCELLS - 1));
    end else if (kind < 86) begin
      queue_op(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 2047));
    end else if (kind < 92) begin
      queue_op(CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 2047));
    end else begin
      queue_op($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 2047));
    end
  endfunction

  task automatic report_mismatch(string what, int got, int expected_val);
    $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
             results_seen, what, got, expected_val);
    errors++;
  endtask

  task automatic set_attribute(logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shadow_attr = value;
    attr_writes++;
  endtask

  // block until the pipe is empty and every result is back
  task automatic drain();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // occasional stretches with no idling on either side
  always @(negedge clk) begin
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(40, 300);
    end else begin
      calm_left--;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        next_op = pending_ops.pop_front();
        cmd <= next_op.cmd;
        char_code <= next_op.char_code;
        cell_address <= next_op.cell_address;
        in_valid <= 1'b1;
        send_gap = calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (sink_stall == 0);
      if (sink_stall > 0) sink_stall--;
      else if (!calm && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_fired = 1'b0;
      idle_cycles = 0;
    end else begin
      in_fired = in_valid && in_ready;
      if (in_fired)
        expected_results.push_back(console_step('{cmd: cmd, char_code: char_code,
                                                  cell_address: cell_address}));
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transaction pending", read_cell, 0);
        end else begin
          want = expected_results.pop_front();
          if (read_cell !== want.read_cell)
            report_mismatch("read_cell", read_cell, want.read_cell);
          if (cursor_row !== want.cursor_row)
            report_mismatch("cursor_row", cursor_row, want.cursor_row);
          if (cursor_col !== want.cursor_col)
            report_mismatch("cursor_col", cursor_col, want.cursor_col);
        end
      end
      if (in_fired || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                   IDLE_LIMIT, expected_results.size());
          $display("testbench NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NCELLS; i++) shadow_cells[i] = CELL_RESET;
    shadow_attr = ATTR_RESET;
    shadow_row = 0;
    shadow_col = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // hold off until the store init pass is done
    while (in_ready !== 1'b1) @(negedge clk);

    // directed checks at the reset attribute
    queue_op(CMD_READ, 8'h00, 11'd0);
    queue_op(CMD_READ, 8'h00, NCELLS - 1);
    queue_op(CMD_READ, 8'hFF, 11'h7FF);
    queue_op(CMD_NONE, 8'hFF, 11'h7FF);
    queue_op(CMD_PUT, CH_BS, 11'd0);
    queue_op(CMD_PUT, 8'h00, 11'd0);
    queue_op(CMD_PUT, 8'hFF, 11'd0);
    queue_op(CMD_PUT, 8'h41, 11'd0);
    queue_op(CMD_READ, 8'h00, 11'd1);
    queue_op(CMD_PUT, CH_TAB, 11'd0);
    queue_op(CMD_PUT, CH_TAB, 11'd0);
    queue_op(CMD_PUT, CH_BS, 11'd0);
    queue_op(CMD_PUT, CH_CR, 11'd0);
    queue_op(CMD_PUT, CH_BS, 11'd0);
    queue_op(CMD_PUT, CH_LF, 11'd0);
    queue_op(CMD_PUT, CH_BS, 11'd0);
    queue_op(CMD_PUT, 8'h78, 11'd0);
    queue_op(CMD_PUT, CH_TAB, 11'd0);
    queue_op(CMD_PUT, CH_CR, 11'd0);
    queue_op(CMD_PUT, CH_BS, 11'd0);
    queue_op(CMD_PUT, 8'h79, 11'd0);
    queue_op(CMD_PUT, 8'h7A, 11'd0);
    queue_op(CMD_READ, 8'h00, NCOLS - 1);
    queue_op(CMD_CLEAR, 8'h00, 11'd0);
    queue_op(CMD_READ, 8'h00, NCOLS);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_attribute(8'hFF);
        1: set_attribute(8'h00);
        2: set_attribute(8'h80);
        3: set_attribute(8'h01);
        default: set_attribute($urandom_range(0, 255));
      endcase
      while (ops_queued < 25 + RANDOM_OPS * (p + 1) / PHASES) add_random_burst();
      drain();
    end

    $display("ran %0d console transactions over %0d attribute settings: %0d reads,",
             ops_queued, attr_writes + 1, read_count);
    $display("%0d scrolls, %0d clears, %0d results checked", scroll_count, clear_count,
             results_seen);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ctw_pkg.sv
src/ctw_screen_mem.sv
src/ctw_engine.sv
src/text_console_writer.sv
verif/testbench.sv
